### hw/rtl/anova_pkg.sv
// Shared types, constants and codes for the two-group ANOVA F statistic core.
package anova_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int MAX_PAIRS_DEF   = 65536;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int IN_BITS    = 16;
   localparam int F_BITS     = 32;
   localparam int PCNT_BITS  = 17;
   localparam int DIV_CNT_BITS = $clog2(F_BITS);

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FEW  = 2'd1,
      ST_ZERO = 2'd2,
      ST_SAT  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      M_IDLE,
      M_START,
      M_WAIT,
      M_SAT,
      M_DIV,
      M_OUT
   } merge_state_type;

   typedef enum logic [2:0] {
      OP_NQ,
      OP_SX,
      OP_SY,
      OP_DF,
      OP_NUM
   } op_type;

   typedef struct packed {
      logic signed [IN_BITS-1:0] x_sample;
      logic signed [IN_BITS-1:0] y_sample;
      logic                      last;
   } req_type;

   typedef struct packed {
      logic [F_BITS-1:0]    f_value;
      status_type           status;
      logic [PCNT_BITS-1:0] pair_count;
   } rsp_type;

endpackage

### hw/rtl/anova_lane.sv
// One group lane: squares each sample and accumulates the sum and the sum of squares.
module anova_lane #(
   parameter int SAMPLE_BITS = anova_pkg::SAMPLE_BITS_DEF,
   parameter int CNT_BITS    = 17
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           in_en,
   input  logic [anova_pkg::IN_BITS-1:0]                  in_sample,
   input  logic                                           clr,
   output logic signed [SAMPLE_BITS+CNT_BITS-1:0]         sum,
   output logic [2*SAMPLE_BITS-2+CNT_BITS-1:0]            sq_sum
);
   import anova_pkg::*;

   localparam int SUMW = SAMPLE_BITS + CNT_BITS;
   localparam int SQW  = 2*SAMPLE_BITS - 2 + CNT_BITS;
   localparam int PW   = 2*SAMPLE_BITS - 1;

   logic signed [SAMPLE_BITS-1:0]   s1_ff, s2_ff;
   logic                            en1_ff, en2_ff;
   logic signed [2*SAMPLE_BITS-1:0] prod;
   logic [PW-1:0]                   sq2_ff;
   logic signed [SUMW-1:0]          sum_ff, sum_in;
   logic [SQW-1:0]                  sq_ff, sq_in;

   assign prod = s1_ff * s1_ff;

   always_comb begin
      sum_in = sum_ff;
      sq_in  = sq_ff;
      if (clr) begin
         sum_in = '0;
         sq_in  = '0;
      end else if (en2_ff) begin
         sum_in = sum_ff + SUMW'(s2_ff);
         sq_in  = sq_ff + SQW'(sq2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en1_ff <= 1'b0;
         en2_ff <= 1'b0;
         sum_ff <= '0;
         sq_ff  <= '0;
      end else begin
         en1_ff <= in_en;
         en2_ff <= en1_ff;
         sum_ff <= sum_in;
         sq_ff  <= sq_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff  <= SAMPLE_BITS'($unsigned(in_sample));
      s2_ff  <= s1_ff;
      sq2_ff <= prod[PW-1:0];
   end

   assign sum    = sum_ff;
   assign sq_sum = sq_ff;

endmodule

### hw/rtl/anova_mul.sv
// Shift-and-add multiplier that retires one multiplier bit per cycle.
module anova_mul #(
   parameter int AW = 64,
   parameter int BW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [AW-1:0] a,
   input  logic [BW-1:0] b,
   output logic          busy,
   output logic [AW-1:0] prod
);
   import anova_pkg::*;

   logic [AW-1:0] acc_ff, acc_in, mc_ff, mc_in;
   logic [BW-1:0] mp_ff, mp_in;

   always_comb begin
      acc_in = acc_ff;
      mc_in  = mc_ff;
      mp_in  = mp_ff;
      if (start) begin
         acc_in = '0;
         mc_in  = a;
         mp_in  = b;
      end else if (|mp_ff) begin
         if (mp_ff[0]) begin
            acc_in = acc_ff + mc_ff;
         end
         mc_in = mc_ff << 1;
         mp_in = mp_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mp_ff <= '0;
      end else begin
         mp_ff <= mp_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
   end

   assign busy = |mp_ff;
   assign prod = acc_ff;

endmodule

### hw/rtl/anova_merge.sv
// Merging stage: forms the F statistic from both lanes' totals and holds the result.
module anova_merge #(
   parameter int SAMPLE_BITS = anova_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = anova_pkg::FRAC_BITS_DEF,
   parameter int CNT_BITS    = 17
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic [CNT_BITS-1:0]                     n,
   input  logic signed [SAMPLE_BITS+CNT_BITS-1:0]  sx,
   input  logic signed [SAMPLE_BITS+CNT_BITS-1:0]  sy,
   input  logic [2*SAMPLE_BITS-2+CNT_BITS-1:0]     qx,
   input  logic [2*SAMPLE_BITS-2+CNT_BITS-1:0]     qy,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output anova_pkg::rsp_type                      rsp_data,
   output logic                                    idle
);
   import anova_pkg::*;

   localparam int SUMW = SAMPLE_BITS + CNT_BITS;
   localparam int SQW  = 2*SAMPLE_BITS - 2 + CNT_BITS;
   localparam int BW   = SUMW + 1;
   localparam int DW   = 2*SAMPLE_BITS + 2*CNT_BITS - 1;
   localparam int MW   = 2*SAMPLE_BITS + 3*CNT_BITS;
   localparam int P4W  = 2*BW;
   localparam int NW   = MW + FRAC_BITS;
   localparam int XW   = (NW > DW + F_BITS) ? NW : DW + F_BITS;
   localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(F_BITS - 1);

   merge_state_type             state_ff, state_in;
   op_type                      op_ff, op_in;
   logic [CNT_BITS-1:0]         n_ff, n_in;
   logic signed [SUMW-1:0]      sx_ff, sx_in, sy_ff, sy_in;
   logic [SQW:0]                q_ff, q_in;
   logic [DW-1:0]               d_ff, d_in;
   logic [P4W-1:0]              p4_ff, p4_in;
   logic [XW-1:0]               rem_ff, rem_in, dv_ff, dv_in;
   logic [F_BITS-1:0]           fq_ff, fq_in;
   status_type                  st_ff, st_in;
   logic [DIV_CNT_BITS-1:0]     step_ff, step_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_data_ff, rsp_data_in;

   logic signed [BW-1:0]        sxe, sye, dfe;
   logic [BW-1:0]               mag_sx, mag_sy, mag_df;
   logic                        mul_start, mul_busy, ge;
   logic [MW-1:0]               mul_a, mul_prod;
   logic [BW-1:0]               mul_b;

   anova_mul #(
      .AW(MW),
      .BW(BW)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .busy  (mul_busy),
      .prod  (mul_prod)
   );

   assign sxe    = BW'(sx_ff);
   assign sye    = BW'(sy_ff);
   assign dfe    = sxe - sye;
   assign mag_sx = sxe[BW-1] ? $unsigned(-sxe) : $unsigned(sxe);
   assign mag_sy = sye[BW-1] ? $unsigned(-sye) : $unsigned(sye);
   assign mag_df = dfe[BW-1] ? $unsigned(-dfe) : $unsigned(dfe);
   assign ge     = rem_ff >= dv_ff;

   assign mul_start = (state_ff == M_START);

   always_comb begin
      case (op_ff)
         OP_NQ: begin
            mul_a = MW'(q_ff);
            mul_b = BW'(n_ff);
         end
         OP_SX: begin
            mul_a = MW'(mag_sx);
            mul_b = mag_sx;
         end
         OP_SY: begin
            mul_a = MW'(mag_sy);
            mul_b = mag_sy;
         end
         OP_DF: begin
            mul_a = MW'(mag_df);
            mul_b = mag_df;
         end
         OP_NUM: begin
            mul_a = MW'(p4_ff);
            mul_b = BW'(n_ff - CNT_BITS'(1));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      n_in         = n_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      q_in         = q_ff;
      d_in         = d_ff;
      p4_in        = p4_ff;
      rem_in       = rem_ff;
      dv_in        = dv_ff;
      fq_in        = fq_ff;
      st_in        = st_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         M_IDLE: begin
            if (start) begin
               n_in  = n;
               sx_in = sx;
               sy_in = sy;
               q_in  = (SQW+1)'(qx) + (SQW+1)'(qy);
               if (n < CNT_BITS'(2)) begin
                  fq_in    = '0;
                  st_in    = ST_FEW;
                  state_in = M_OUT;
               end else begin
                  op_in    = OP_NQ;
                  state_in = M_START;
               end
            end
         end
         M_START: begin
            state_in = M_WAIT;
         end
         M_WAIT: begin
            if (!mul_busy) begin
               state_in = M_START;
               case (op_ff)
                  OP_NQ: begin
                     d_in  = mul_prod[DW-1:0];
                     op_in = OP_SX;
                  end
                  OP_SX: begin
                     d_in  = d_ff - mul_prod[DW-1:0];
                     op_in = OP_SY;
                  end
                  OP_SY: begin
                     d_in  = d_ff - mul_prod[DW-1:0];
                     op_in = OP_DF;
                  end
                  OP_DF: begin
                     p4_in = mul_prod[P4W-1:0];
                     op_in = OP_NUM;
                  end
                  OP_NUM: begin
                     rem_in   = XW'(mul_prod) << FRAC_BITS;
                     state_in = M_SAT;
                  end
                  default: begin
                     state_in = M_IDLE;
                  end
               endcase
            end
         end
         M_SAT: begin
            if (d_ff == '0) begin
               fq_in    = '0;
               st_in    = ST_ZERO;
               state_in = M_OUT;
            end else if (rem_ff >= (XW'(d_ff) << F_BITS)) begin
               fq_in    = '1;
               st_in    = ST_SAT;
               state_in = M_OUT;
            end else begin
               dv_in    = XW'(d_ff) << (F_BITS - 1);
               fq_in    = '0;
               step_in  = '0;
               state_in = M_DIV;
            end
         end
         M_DIV: begin
            if (ge) begin
               rem_in = rem_ff - dv_ff;
            end
            fq_in   = {fq_ff[F_BITS-2:0], ge};
            dv_in   = dv_ff >> 1;
            step_in = step_ff + DIV_CNT_BITS'(1);
            if (step_ff == DIV_LAST) begin
               st_in    = ST_OK;
               state_in = M_OUT;
            end
         end
         M_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.f_value    = fq_ff;
               rsp_data_in.status     = st_ff;
               rsp_data_in.pair_count = PCNT_BITS'(n_ff);
               rsp_valid_in           = 1'b1;
               state_in               = M_IDLE;
            end
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= M_IDLE;
         op_ff        <= OP_NQ;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      q_ff        <= q_in;
      d_ff        <= d_in;
      p4_ff       <= p4_in;
      rem_ff      <= rem_in;
      dv_ff       <= dv_in;
      fq_ff       <= fq_in;
      st_ff       <= st_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign idle      = (state_ff == M_IDLE);

endmodule

### hw/rtl/two_group_anova_f_statistic_core.sv
// Top level of the two-group one-way ANOVA F statistic core.
//
// Each req_ transfer carries one sample of each group and a last marker. The
// two group lanes square and accumulate one pair per cycle, so a data set of
// n pairs streams in at one pair per clock. Pairs beyond MAX_PAIRS are
// dropped, but their last marker still closes the data set.
// After the transfer that carries last, req_ready stays low while the merging
// stage forms the statistic. Its shared shift-and-add multiplier runs five
// products one after another, and a restoring divider then forms the
// quotient bit by bit before the result is written out.
// The result sits in an output register. Once it is written there, req_ready
// rises again and the next data set streams in even while rsp_ready is low;
// a following result waits in the merging stage until the register frees.
// A synchronous reset clears all accumulators and drops any pending result.
module two_group_anova_f_statistic_core #(
   parameter int SAMPLE_BITS = anova_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_PAIRS   = anova_pkg::MAX_PAIRS_DEF,
   parameter int FRAC_BITS   = anova_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  anova_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output anova_pkg::rsp_type rsp_data
);
   import anova_pkg::*;

   localparam int CW   = $clog2(MAX_PAIRS + 1);
   localparam int SUMW = SAMPLE_BITS + CW;
   localparam int SQW  = 2*SAMPLE_BITS - 2 + CW;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PAIRS);

   logic                   accept, take, merge_idle;
   logic                   hold_ff, hold_in;
   logic                   last1_ff, last2_ff, last3_ff;
   logic [CW-1:0]          n_ff, n_in;
   logic signed [SUMW-1:0] sx, sy;
   logic [SQW-1:0]         qx, qy;

   assign accept = req_valid & req_ready;
   assign take   = accept & (n_ff < MAX_CNT);

   always_comb begin
      n_in = n_ff;
      if (last3_ff) begin
         n_in = '0;
      end else if (take) begin
         n_in = n_ff + CW'(1);
      end
   end

   always_comb begin
      hold_in = hold_ff;
      if (accept && req_data.last) begin
         hold_in = 1'b1;
      end else if (hold_ff && merge_idle && !last1_ff && !last2_ff && !last3_ff) begin
         hold_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff  <= 1'b0;
         last1_ff <= 1'b0;
         last2_ff <= 1'b0;
         last3_ff <= 1'b0;
         n_ff     <= '0;
      end else begin
         hold_ff  <= hold_in;
         last1_ff <= accept & req_data.last;
         last2_ff <= last1_ff;
         last3_ff <= last2_ff;
         n_ff     <= n_in;
      end
   end

   assign req_ready = ~hold_ff;

   anova_lane #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .CNT_BITS   (CW)
   ) u_lane_x (
      .clock     (clock),
      .reset     (reset),
      .in_en     (take),
      .in_sample (req_data.x_sample),
      .clr       (last3_ff),
      .sum       (sx),
      .sq_sum    (qx)
   );

   anova_lane #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .CNT_BITS   (CW)
   ) u_lane_y (
      .clock     (clock),
      .reset     (reset),
      .in_en     (take),
      .in_sample (req_data.y_sample),
      .clr       (last3_ff),
      .sum       (sy),
      .sq_sum    (qy)
   );

   anova_merge #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .CNT_BITS   (CW)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .start     (last3_ff),
      .n         (n_ff),
      .sx        (sx),
      .sy        (sy),
      .qx        (qx),
      .qy        (qy),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .idle      (merge_idle)
   );

`ifndef NO_ASSERTIONS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      last3_ff |-> merge_idle)
      else $error("Data set closed while the merging stage was busy.");

   a_hold_covers_last: assert property (@(posedge clock) disable iff (reset)
      (last1_ff || last2_ff || last3_ff) |-> hold_ff)
      else $error("Input open while a last pair is still in the lanes.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= MAX_CNT)
      else $error("Pair count exceeds the configured maximum.");

   a_no_accept_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.last) |=> !req_ready)
      else $error("Input accepted a transfer right after a last pair.");
`endif

endmodule
